// ----- rtl/vqbcd_pkg.sv -----
`default_nettype none

package vqbcd_pkg;

    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int DETAIL_ENTRIES = 256;
    localparam int SMOOTH_WORDS   = 1024;

    localparam int DETAIL_AW = $clog2(DETAIL_ENTRIES);
    localparam int SMOOTH_AW = $clog2(SMOOTH_WORDS);
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] COL_CAP = DIM_W'(MAX_COLS < 256 ? MAX_COLS : 256);
    localparam logic [DIM_W-1:0] ROW_CAP = DIM_W'(MAX_ROWS < 256 ? MAX_ROWS : 256);

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef enum logic [1:0] {
        CMD_DETAIL_WR = 2'd0,
        CMD_SMOOTH_WR = 2'd1,
        CMD_START     = 2'd2,
        CMD_DATA      = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [9:0]  table_index;
        logic [31:0] table_word;
        logic [7:0]  data_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  block_col;
        logic [7:0]  block_row;
        logic [1:0]  row_in_block;
        logic [31:0] pixel_row;
        logic        last_row;
    } out_word_t;

    typedef struct packed {
        logic                 det_we;
        logic                 smo_we;
        logic [SMOOTH_AW-1:0] addr;
        logic [31:0]          data;
    } book_wr_t;

    // zero acts as one, then saturate to the cap
    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] cap);
        logic [DIM_W-1:0] r;
        r = v;
        if (r == '0) begin
            r = DIM_W'(1);
        end
        if (r > cap) begin
            r = cap;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vqbcd_books.sv -----
`default_nettype none

module vqbcd_books (
    input  wire                              aclk,
    input  vqbcd_pkg::book_wr_t              wr,
    input  wire [vqbcd_pkg::DETAIL_AW-1:0]   det_raddr,
    input  wire [vqbcd_pkg::SMOOTH_AW-1:0]   smo_raddr,
    output logic [31:0]                      det_q,
    output logic [31:0]                      smo_q
);
    import vqbcd_pkg::*;

    logic [31:0] det_mem [DETAIL_ENTRIES];
    logic [31:0] smo_mem [SMOOTH_WORDS];

    always_ff @(posedge aclk) begin
        if (wr.det_we) begin
            det_mem[wr.addr[DETAIL_AW-1:0]] <= wr.data;
        end
        det_q <= det_mem[det_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr.smo_we) begin
            smo_mem[wr.addr] <= wr.data;
        end
        smo_q <= smo_mem[smo_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/vq_block_codebook_decoder.sv -----
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_data   (in_word_t)
// m_        out        m_valid / m_ready      m_data   (out_word_t, one pixel row)
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// codebook writes, flag bytes and index bytes are accepted while the decoder sits in S_READY
// the flag sequencer handles one flag per S_DECIDE step, so each skipped block costs a step
// smooth and detail rows load after the index byte through the registered book port; in an
// intra frame input reopens once the last row is issued and the next flag step has run
// reset is synchronous active low; books are not cleared and need loading first
// m_ready low holds the row sequence; input waits while a block or flag step runs

`default_nettype none

module vq_block_codebook_decoder (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  vqbcd_pkg::in_word_t              s_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    output vqbcd_pkg::out_word_t             m_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [vqbcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [vqbcd_pkg::DIM_W-1:0]       cfg_data
);
    import vqbcd_pkg::*;

    typedef enum logic [2:0] {
        S_READY  = 3'b001,
        S_DECIDE = 3'b010,
        S_BLOCK  = 3'b100
    } state_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_FLAG1  = 5'b00010,
        PH_FLAG2  = 5'b00100,
        PH_SMOOTH = 5'b01000,
        PH_DETAIL = 5'b10000
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               second_reg, second_next;
    logic [31:0]        flag_bits_reg, flag_bits_next;
    logic [5:0]         flags_rem_reg, flags_rem_next;
    logic [1:0]         gather_cnt_reg, gather_cnt_next;
    logic [23:0]        gathered_reg, gathered_next;
    logic [7:0]         col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic               mode_reg, mode_next;
    logic [7:0]         byte_reg, byte_next;
    logic               is_detail_reg, is_detail_next;
    logic [2:0]         got_cnt_reg, got_cnt_next;
    logic [1:0]         emit_cnt_reg, emit_cnt_next;
    logic [31:0]        w_reg [4];
    logic [31:0]        w_next [4];
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_data_reg, m_data_next;

    book_wr_t               book_wr;
    logic [DETAIL_AW-1:0]   det_raddr;
    logic [SMOOTH_AW-1:0]   smo_raddr;
    logic [31:0]            det_q;
    logic [31:0]            smo_q;

    logic                   acc;
    logic [1:0]             fetch_idx;
    logic [DIM_W-1:0]       wlim;
    logic [DIM_W-1:0]       hlim;
    logic [DIM_W-1:0]       col_inc;
    logic                   col_wrap;
    logic [7:0]             adv_col;
    logic [DIM_W-1:0]       adv_row;
    logic                   can_load;
    logic [2:0]             need;
    logic [31:0]            pa;
    logic [31:0]            pb;
    logic [31:0]            row_word;

    assign s_ready   = (state_reg == S_READY);
    assign acc       = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // read address runs one ahead of the words already captured
    assign fetch_idx = acc ? 2'd0 : (got_cnt_reg[1:0] + 2'd1);

    always_comb begin
        case (fetch_idx)
            2'd0:    det_raddr = gathered_reg[23:16];
            2'd1:    det_raddr = gathered_reg[15:8];
            2'd2:    det_raddr = gathered_reg[7:0];
            default: det_raddr = byte_reg;
        endcase
    end

    assign smo_raddr = acc ? {s_data.data_byte, 2'd0} : {byte_reg, fetch_idx};

    vqbcd_books u_books (
        .aclk      (aclk),
        .wr        (book_wr),
        .det_raddr (det_raddr),
        .smo_raddr (smo_raddr),
        .det_q     (det_q),
        .smo_q     (smo_q)
    );

    assign wlim     = limit_dim(width_reg, COL_CAP);
    assign hlim     = limit_dim(height_reg, ROW_CAP);
    assign col_inc  = {1'b0, col_reg} + DIM_W'(1);
    assign col_wrap = (col_inc >= wlim);
    assign adv_col  = col_wrap ? 8'd0 : col_inc[7:0];
    assign adv_row  = col_wrap ? (row_reg + DIM_W'(1)) : row_reg;
    assign can_load = !m_valid_reg || m_ready;

    // detail rows pair the top or bottom halves of two patches
    assign pa       = emit_cnt_reg[1] ? w_reg[2] : w_reg[0];
    assign pb       = emit_cnt_reg[1] ? w_reg[3] : w_reg[1];
    assign row_word = !is_detail_reg ? w_reg[emit_cnt_reg] :
                      emit_cnt_reg[0] ? {pa[15:0], pb[15:0]} : {pa[31:16], pb[31:16]};
    assign need     = !is_detail_reg ? {1'b0, emit_cnt_reg} :
                      (emit_cnt_reg[1] ? 3'd3 : 3'd1);

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        second_next     = second_reg;
        flag_bits_next  = flag_bits_reg;
        flags_rem_next  = flags_rem_reg;
        gather_cnt_next = gather_cnt_reg;
        gathered_next   = gathered_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        mode_next       = mode_reg;
        byte_next       = byte_reg;
        is_detail_next  = is_detail_reg;
        got_cnt_next    = got_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        for (int i = 0; i < 4; i++) begin
            w_next[i] = w_reg[i];
        end
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        book_wr.det_we  = 1'b0;
        book_wr.smo_we  = 1'b0;
        book_wr.addr    = s_data.table_index;
        book_wr.data    = s_data.table_word;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                CFG_MODE:   mode_next   = cfg_data[0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_READY: begin
                if (s_valid) begin
                    case (s_data.command)
                        CMD_DETAIL_WR: begin
                            book_wr.det_we = (s_data.table_index < 10'(DETAIL_ENTRIES));
                        end
                        CMD_SMOOTH_WR: begin
                            book_wr.smo_we = 1'b1;
                        end
                        CMD_START: begin
                            col_next       = '0;
                            row_next       = '0;
                            flag_bits_next = '0;
                            flags_rem_next = '0;
                            second_next    = 1'b0;
                            state_next     = S_DECIDE;
                        end
                        CMD_DATA: begin
                            case (phase_reg)
                                PH_FLAG1, PH_FLAG2: begin
                                    flag_bits_next  = {flag_bits_reg[23:0], s_data.data_byte};
                                    gather_cnt_next = gather_cnt_reg + 2'd1;
                                    if (gather_cnt_reg == 2'd3) begin
                                        flags_rem_next = 6'd32;
                                        second_next    = (phase_reg == PH_FLAG2);
                                        state_next     = S_DECIDE;
                                    end
                                end
                                PH_SMOOTH: begin
                                    byte_next      = s_data.data_byte;
                                    is_detail_next = 1'b0;
                                    got_cnt_next   = '0;
                                    emit_cnt_next  = '0;
                                    state_next     = S_BLOCK;
                                end
                                PH_DETAIL: begin
                                    if (gather_cnt_reg != 2'd3) begin
                                        gathered_next   = {gathered_reg[15:0], s_data.data_byte};
                                        gather_cnt_next = gather_cnt_reg + 2'd1;
                                    end else begin
                                        byte_next      = s_data.data_byte;
                                        is_detail_next = 1'b1;
                                        got_cnt_next   = '0;
                                        emit_cnt_next  = '0;
                                        state_next     = S_BLOCK;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_DECIDE: begin
                if (!second_reg && (row_reg >= hlim)) begin
                    phase_next      = PH_IDLE;
                    gather_cnt_next = '0;
                    gathered_next   = '0;
                    state_next      = S_READY;
                end else if (flags_rem_reg == '0) begin
                    phase_next      = second_reg ? PH_FLAG2 : PH_FLAG1;
                    gather_cnt_next = '0;
                    gathered_next   = '0;
                    state_next      = S_READY;
                end else begin
                    flag_bits_next = {flag_bits_reg[30:0], 1'b0};
                    flags_rem_next = flags_rem_reg - 6'd1;
                    if (!second_reg && mode_reg) begin
                        // inter frame: a clear first flag skips the block
                        if (!flag_bits_reg[31]) begin
                            col_next = adv_col;
                            row_next = adv_row;
                        end else begin
                            second_next = 1'b1;
                        end
                    end else begin
                        phase_next      = flag_bits_reg[31] ? PH_DETAIL : PH_SMOOTH;
                        gather_cnt_next = '0;
                        gathered_next   = '0;
                        state_next      = S_READY;
                    end
                end
            end
            S_BLOCK: begin
                if (got_cnt_reg != 3'd4) begin
                    w_next[got_cnt_reg[1:0]] = is_detail_reg ? det_q : smo_q;
                    got_cnt_next             = got_cnt_reg + 3'd1;
                end
                if (can_load && (got_cnt_reg > need)) begin
                    m_valid_next              = 1'b1;
                    m_data_next.block_col     = col_reg;
                    m_data_next.block_row     = row_reg[7:0];
                    m_data_next.row_in_block  = emit_cnt_reg;
                    m_data_next.pixel_row     = row_word;
                    m_data_next.last_row      = (emit_cnt_reg == 2'd3);
                    emit_cnt_next             = emit_cnt_reg + 2'd1;
                    if (emit_cnt_reg == 2'd3) begin
                        col_next    = adv_col;
                        row_next    = adv_row;
                        second_next = 1'b0;
                        state_next  = S_DECIDE;
                    end
                end
            end
            default: begin
                state_next = S_READY;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_READY;
            phase_reg      <= PH_IDLE;
            second_reg     <= 1'b0;
            flag_bits_reg  <= '0;
            flags_rem_reg  <= '0;
            gather_cnt_reg <= '0;
            gathered_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            width_reg      <= DIM_W'(1);
            height_reg     <= DIM_W'(1);
            mode_reg       <= 1'b0;
            got_cnt_reg    <= '0;
            emit_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            second_reg     <= second_next;
            flag_bits_reg  <= flag_bits_next;
            flags_rem_reg  <= flags_rem_next;
            gather_cnt_reg <= gather_cnt_next;
            gathered_reg   <= gathered_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            mode_reg       <= mode_next;
            got_cnt_reg    <= got_cnt_next;
            emit_cnt_reg   <= emit_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        is_detail_reg <= is_detail_next;
        for (int i = 0; i < 4; i++) begin
            w_reg[i] <= w_next[i];
        end
        m_data_reg    <= m_data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/vqbcd_checker.sv -----
`default_nettype none

module vqbcd_checker (
    input wire                              aclk,
    input wire                              aresetn,
    input wire                              s_ready,
    input vqbcd_pkg::out_word_t             m_data,
    input wire                              m_valid,
    input wire                              m_ready,
    input wire                              cfg_valid,
    input wire                              cfg_ready
);
    import vqbcd_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not quiet after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled word changed");

    // a word right after a taken non-last row, if valid, is the next row of the same block
    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_row |=> !m_valid ||
            (m_data.row_in_block == $past(m_data.row_in_block) + 2'd1 &&
             m_data.block_col == $past(m_data.block_col) &&
             m_data.block_row == $past(m_data.block_row)))
        else $error("row sequence broken");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_row |=> !m_valid ||
            m_data.row_in_block == 2'd0)
        else $error("new block does not start at row zero");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind vq_block_codebook_decoder vqbcd_checker u_vqbcd_checker (.*);

`default_nettype wire

// ----- tb/tb_vq_block_codebook_decoder.sv -----
`default_nettype none

module tb_vq_block_codebook_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import vqbcd_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 36;
    localparam int SETTLE_CYCLES = 64;

    typedef enum logic [2:0] {
        P_IDLE,
        P_FLAG1,
        P_FLAG2,
        P_SMOOTH,
        P_DETAIL
    } parse_t;

    typedef struct {
        in_word_t          w;
        bit                typed;
        logic [0:3][31:0]  px;
    } script_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    in_word_t             s_data = '0;
    logic                 s_valid = 1'b0;
    wire                  s_ready;
    out_word_t            m_data;
    wire                  m_valid;
    logic                 m_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    wire                  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    // decoder image
    logic [31:0]      det_mem [0:DETAIL_ENTRIES-1];
    logic [31:0]      smo_mem [0:SMOOTH_WORDS-1];
    logic [31:0]      flag_reg = '0;
    logic [5:0]       flags_left = '0;
    logic [2:0]       idx_cnt = '0;
    logic [23:0]      idx_acc = '0;
    logic [8:0]       col_pos = '0;
    logic [8:0]       row_pos = '0;
    parse_t           phase_now = P_IDLE;
    logic [8:0]       cols_cfg = 9'd1;
    logic [8:0]       rows_cfg = 9'd1;
    logic             inter_cfg = 1'b0;

    out_word_t        rows_due [$];
    script_row_t      script [$];
    bit               typed_on = 1'b0;
    logic [0:3][31:0] typed_px = '0;

    int fails = 0;
    int quiet = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    vq_block_codebook_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [8:0] dim_eff(input logic [8:0] v, input logic [8:0] cap);
        logic [8:0] e;
        e = (v == 9'd0) ? 9'd1 : v;
        if (e > cap) begin
            e = cap;
        end
        return e;
    endfunction

    function automatic bit pop_flag();
        bit b;
        b = flag_reg[31];
        flag_reg = flag_reg << 1;
        flags_left = flags_left - 6'd1;
        return b;
    endfunction

    function automatic void step_pos();
        col_pos = col_pos + 9'd1;
        if (col_pos >= dim_eff(cols_cfg, COL_CAP)) begin
            col_pos = '0;
            row_pos = row_pos + 9'd1;
        end
    endfunction

    function automatic void enter(input parse_t p);
        phase_now = p;
        idx_cnt = '0;
        idx_acc = '0;
    endfunction

    function automatic void choose_next(input bit second);
        bit sec;
        bit done;
        sec = second;
        done = 1'b0;
        while (!done) begin
            if (!sec) begin
                if (row_pos >= dim_eff(rows_cfg, ROW_CAP)) begin
                    enter(P_IDLE);
                    done = 1'b1;
                end else if (flags_left == 6'd0) begin
                    enter(P_FLAG1);
                    done = 1'b1;
                end else if (inter_cfg) begin
                    if (pop_flag()) begin
                        sec = 1'b1;
                    end else begin
                        step_pos();
                    end
                end else begin
                    enter(pop_flag() ? P_DETAIL : P_SMOOTH);
                    done = 1'b1;
                end
            end else begin
                if (flags_left == 6'd0) begin
                    enter(P_FLAG2);
                end else begin
                    enter(pop_flag() ? P_DETAIL : P_SMOOTH);
                end
                done = 1'b1;
            end
        end
    endfunction

    function automatic void queue_block(input logic [0:3][31:0] px);
        out_word_t o;
        for (int r = 0; r < 4; r++) begin
            o.block_col    = col_pos[7:0];
            o.block_row    = row_pos[7:0];
            o.row_in_block = r[1:0];
            o.pixel_row    = typed_on ? typed_px[r] : px[r];
            o.last_row     = (r == 3);
            rows_due.push_back(o);
        end
        step_pos();
        choose_next(1'b0);
    endfunction

    function automatic void predict_word(input in_word_t w);
        logic [0:3][31:0] px;
        logic [31:0] a, b, c, d;
        case (w.command)
            CMD_DETAIL_WR: begin
                if (w.table_index < 10'd256) begin
                    det_mem[w.table_index[7:0]] = w.table_word;
                end
            end
            CMD_SMOOTH_WR: smo_mem[w.table_index] = w.table_word;
            CMD_START: begin
                col_pos = '0;
                row_pos = '0;
                flag_reg = '0;
                flags_left = '0;
                choose_next(1'b0);
            end
            default: begin
                case (phase_now)
                    P_FLAG1, P_FLAG2: begin
                        flag_reg = {flag_reg[23:0], w.data_byte};
                        idx_cnt = idx_cnt + 3'd1;
                        if (idx_cnt >= 3'd4) begin
                            flags_left = 6'd32;
                            choose_next(phase_now == P_FLAG2);
                        end
                    end
                    P_SMOOTH: begin
                        for (int r = 0; r < 4; r++) begin
                            px[r] = smo_mem[{w.data_byte, r[1:0]}];
                        end
                        queue_block(px);
                    end
                    P_DETAIL: begin
                        if (idx_cnt < 3'd3) begin
                            idx_acc = {idx_acc[15:0], w.data_byte};
                            idx_cnt = idx_cnt + 3'd1;
                        end else begin
                            a = det_mem[idx_acc[23:16]];
                            b = det_mem[idx_acc[15:8]];
                            c = det_mem[idx_acc[7:0]];
                            d = det_mem[w.data_byte];
                            px[0] = {a[31:16], b[31:16]};
                            px[1] = {a[15:0], b[15:0]};
                            px[2] = {c[31:16], d[31:16]};
                            px[3] = {c[15:0], d[15:0]};
                            queue_block(px);
                        end
                    end
                    default: ;
                endcase
            end
        endcase
    endfunction

    task automatic check_row(input out_word_t got);
        out_word_t want;
        if (rows_due.size() == 0) begin
            $error("pixel row word with none expected: %h", got);
            fails++;
        end else begin
            want = rows_due.pop_front();
            if (got.block_col !== want.block_col) begin
                $error("block_col expected %0d got %0d", want.block_col, got.block_col);
                fails++;
            end
            if (got.block_row !== want.block_row) begin
                $error("block_row expected %0d got %0d", want.block_row, got.block_row);
                fails++;
            end
            if (got.row_in_block !== want.row_in_block) begin
                $error("row_in_block expected %0d got %0d",
                       want.row_in_block, got.row_in_block);
                fails++;
            end
            if (got.pixel_row !== want.pixel_row) begin
                $error("pixel_row expected %h got %h", want.pixel_row, got.pixel_row);
                fails++;
            end
            if (got.last_row !== want.last_row) begin
                $error("last_row expected %0d got %0d", want.last_row, got.last_row);
                fails++;
            end
        end
    endtask

    always @(posedge aclk) begin : mon
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                check_row(m_data);
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                predict_word(s_data);
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_WIDTH:  cols_cfg = cfg_data;
                    CFG_HEIGHT: rows_cfg = cfg_data;
                    CFG_MODE:   inter_cfg = cfg_data[0];
                    default: ;
                endcase
            end
        end
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side ready, with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input in_word_t w);
        while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (rows_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic add_row(input cmd_t c, input int idx, input logic [31:0] word,
                           input logic [7:0] b, input bit typed,
                           input logic [0:3][31:0] px);
        script_row_t row;
        row.w.command     = c;
        row.w.table_index = idx[9:0];
        row.w.table_word  = word;
        row.w.data_byte   = b;
        row.typed         = typed;
        row.px            = px;
        script.push_back(row);
    endtask

    initial begin
        in_word_t w;
        int n;
        bit skip;
        logic [7:0] ib;
        logic [8:0] set_w [0:7];
        logic [8:0] set_h [0:7];
        bit set_m [0:7];

        set_w = '{9'd1, 9'd4, 9'd0, 9'd511, 9'd256, 9'd2, 9'd7, 9'd300};
        set_h = '{9'd1, 9'd3, 9'd0, 9'd511, 9'd256, 9'd5, 9'd2, 9'd1};
        set_m = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // load the entries that index bytes use: 0 to 15 and 255
        for (int i = 0; i < 17; i++) begin
            ib = (i < 16) ? 8'(i) : 8'hFF;
            w.command     = CMD_DETAIL_WR;
            w.table_index = {2'b00, ib};
            w.table_word  = $urandom;
            w.data_byte   = 8'($urandom);
            send_word(w);
            for (int r = 0; r < 4; r++) begin
                w.command     = CMD_SMOOTH_WR;
                w.table_index = {ib, r[1:0]};
                w.table_word  = $urandom;
                w.data_byte   = 8'($urandom);
                send_word(w);
            end
        end

        add_row(CMD_DATA, 0, '0, 8'hFF, 0, '0);
        add_row(CMD_SMOOTH_WR, 1020, 32'h0000_0000, 8'h00, 0, '0);
        add_row(CMD_SMOOTH_WR, 1021, 32'hFFFF_FFFF, 8'h00, 0, '0);
        add_row(CMD_SMOOTH_WR, 1022, 32'h8000_0001, 8'h00, 0, '0);
        add_row(CMD_SMOOTH_WR, 1023, 32'h7FFF_FFFE, 8'h00, 0, '0);
        add_row(CMD_DETAIL_WR, 0, 32'hFFFF_0000, 8'h00, 0, '0);
        add_row(CMD_DETAIL_WR, 255, 32'h0000_FFFF, 8'h00, 0, '0);
        add_row(CMD_DETAIL_WR, 1023, 32'h1234_5678, 8'h00, 0, '0);
        add_row(CMD_START, 0, '0, 8'h00, 0, '0);
        for (int i = 0; i < 4; i++) begin
            add_row(CMD_DATA, 0, '0, 8'h00, 0, '0);
        end
        add_row(CMD_DATA, 0, '0, 8'hFF, 1,
                {32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE});
        add_row(CMD_DATA, 0, '0, 8'h00, 0, '0);
        add_row(CMD_START, 0, '0, 8'h00, 0, '0);
        for (int i = 0; i < 4; i++) begin
            add_row(CMD_DATA, 0, '0, 8'hFF, 0, '0);
        end
        add_row(CMD_DATA, 0, '0, 8'h00, 0, '0);
        add_row(CMD_SMOOTH_WR, 5, 32'hABCD_0123, 8'h00, 0, '0);
        add_row(CMD_DATA, 0, '0, 8'hFF, 0, '0);
        add_row(CMD_DATA, 0, '0, 8'h00, 0, '0);
        add_row(CMD_DATA, 0, '0, 8'hFF, 1,
                {32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_FFFF});
        add_row(CMD_START, 0, '0, 8'h00, 0, '0);
        add_row(CMD_DATA, 0, '0, 8'h80, 0, '0);
        add_row(CMD_START, 0, '0, 8'h00, 0, '0);

        foreach (script[i]) begin
            typed_on = script[i].typed;
            typed_px = script[i].px;
            send_word(script[i].w);
        end
        typed_on = 1'b0;

        for (int k = 0; k < 8; k++) begin
            drain();
            write_reg(CFG_WIDTH, set_w[k]);
            write_reg(CFG_HEIGHT, set_h[k]);
            write_reg(CFG_MODE, DIM_W'(set_m[k]));
            cfg_valid <= 1'b0;
            case (k % 4)
                0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_gap_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_gap_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_gap_pct = 16; rx_stall_pct = 16; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                if (k == 2 && n == 5) begin
                    hold_req = 1'b1;
                end
                if (k == 5 && n == 25) begin
                    drain();
                end
                w.table_index = 10'($urandom);
                w.table_word  = $urandom;
                w.data_byte   = 8'($urandom);
                case ($urandom_range(99)) inside
                    [0:5]:   w.command = $urandom_range(1) ? CMD_DETAIL_WR : CMD_SMOOTH_WR;
                    [6:7]:   w.command = CMD_START;
                    [8:11]:  w.command = CMD_DATA;
                    default: w.command = (phase_now == P_IDLE) ? CMD_START : CMD_DATA;
                endcase
                // index bytes stay on loaded entries
                if (phase_now == P_SMOOTH || phase_now == P_DETAIL) begin
                    w.data_byte = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(15));
                end
                skip = (w.command == CMD_DATA && phase_now == P_IDLE) ||
                       (w.command == CMD_DETAIL_WR && w.table_index >= 10'd256);
                send_word(w);
                if (!skip) begin
                    n++;
                end
            end
        end

        drain();
        if (fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- vq_block_codebook_decoder.f -----
rtl/vqbcd_pkg.sv
rtl/vqbcd_books.sv
rtl/vq_block_codebook_decoder.sv
rtl/vqbcd_checker.sv
tb/tb_vq_block_codebook_decoder.sv
